// File: hdl/newton_square_root_unit_assert.svh
// assertion macros for the newton square root unit
// used by the checker module only
`ifndef NEWTON_SQUARE_ROOT_UNIT_ASSERT_SVH
`define NEWTON_SQUARE_ROOT_UNIT_ASSERT_SVH
`define NSR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define NSR_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed after reset");
`endif

// File: hdl/nsr_pkg.sv
// shared types and constants of the newton square root unit
// no dependencies
package nsr_pkg;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned DivBits   = ValueBits + FracBits;
  localparam int unsigned GuessBits = 50;
  localparam int unsigned RootBits  = 25;
  localparam int unsigned EpsBits   = 16;
  localparam int unsigned IterBits  = 6;
  localparam int unsigned CntBits   = 6;
  localparam int unsigned SqBits    = 2 * GuessBits;

  localparam logic [1:0] StatusConverged = 2'd0;
  localparam logic [1:0] StatusZero      = 2'd1;
  localparam logic [1:0] StatusLimit     = 2'd2;

  localparam logic RegEpsilon = 1'b0;
  localparam logic RegLimit   = 1'b1;

  typedef struct packed {
    logic load;
    logic div_start;
    logic update;
    logic sq_lo;
    logic sq_hi;
    logic check;
  } nsr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_zero;
    logic within_eps;
  } nsr_status_t;
endpackage

// File: hdl/newton_square_root_unit.sv
// Newton-Raphson square root of one unsigned Q16.16 operand. One item at a
// time: each iteration runs the radix-2 divider, then guess update, squarer,
// compare and decision; the unit also accepts, loads and delivers each item,
// and a zero operand goes from load straight to deliver. Typical operands need
// 5 to 20 iterations, at most the limit.
// depends on nsr_pkg, nsr_controller, nsr_datapath
module newton_square_root_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [nsr_pkg::ValueBits-1:0]     value_i,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nsr_pkg::RootBits-1:0]      root_o,
  output logic [nsr_pkg::IterBits-1:0]      iterations_o,
  output logic [1:0]                        status_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [15:0]                       cfg_data_i
);
  logic [nsr_pkg::EpsBits-1:0]  eps_q;
  logic [nsr_pkg::IterBits-1:0] lim_q;
  nsr_pkg::nsr_cmd_t    cmd;
  nsr_pkg::nsr_status_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= 16'd1;
      lim_q <= 6'd32;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == nsr_pkg::RegEpsilon) eps_q <= cfg_data_i;
      else lim_q <= cfg_data_i[nsr_pkg::IterBits-1:0];
    end
  end

  nsr_controller u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .limit_i(lim_q), .cmd_o(cmd), .sts_i(sts), .iterations_o, .status_o
  );

  nsr_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .value_i,
    .epsilon_i(eps_q), .root_o
  );
endmodule

// File: hdl/nsr_datapath.sv
// datapath: operand, guess, radix-2 divider, split squarer, error compare
// depends on nsr_pkg
module nsr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  nsr_pkg::nsr_cmd_t                   cmd_i,
  output nsr_pkg::nsr_status_t                sts_o,
  input  logic [nsr_pkg::ValueBits-1:0]       value_i,
  input  logic [nsr_pkg::EpsBits-1:0]         epsilon_i,
  output logic [nsr_pkg::RootBits-1:0]        root_o
);
  localparam int unsigned GB = nsr_pkg::GuessBits;
  localparam int unsigned DB = nsr_pkg::DivBits;
  localparam int unsigned HB = GB - 25;
  localparam int unsigned SB = nsr_pkg::SqBits;

  logic [nsr_pkg::ValueBits-1:0] v_q;
  logic [GB-1:0] g_q, g_d;
  logic [DB-1:0] dsh_q;
  logic [GB:0]   rem_q;
  logic [GB-1:0] quo_q;
  logic          sat_q, dbusy_q;
  logic [6:0]    dcnt_q;
  logic [GB-1:0] quo_sh;
  logic [GB+1:0] rem_sh;
  logic [GB:0]   gsum;
  logic [GB-HB-1:0] g_lo;
  logic [HB-1:0]    g_hi;
  logic [2*HB-1:0]  pll_q, plh_q, phh_q;
  logic [nsr_pkg::SqBits-1:0] sq_full;
  logic [63:0]   sq;
  logic [63:0]   err;
  logic          eps_q;

  assign rem_sh = {rem_q, dsh_q[DB-1]};
  assign quo_sh = {quo_q[GB-2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= 7'(DB);
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - 7'd1;
      if (dcnt_q == 7'd1) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dsh_q <= {v_q, {nsr_pkg::FracBits{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
      sat_q <= 1'b0;
    end else if (dbusy_q) begin
      dsh_q <= {dsh_q[DB-2:0], 1'b0};
      if (quo_q[GB-1]) sat_q <= 1'b1;
      if (rem_sh >= {2'b00, g_q}) begin
        rem_q <= (GB+1)'(rem_sh - {2'b00, g_q});
        quo_q <= quo_sh | GB'(1);
      end else begin
        rem_q <= rem_sh[GB:0];
        quo_q <= quo_sh;
      end
    end
  end

  assign gsum = {1'b0, g_q} + {1'b0, (sat_q ? {GB{1'b1}} : quo_q)};

  always_comb begin
    g_d = gsum[GB:1];
    if (g_d == '0) g_d = GB'(1);
  end

  assign g_lo = g_q[GB-HB-1:0];
  assign g_hi = g_q[GB-1:GB-HB];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q <= value_i;
      g_q <= (value_i[nsr_pkg::ValueBits-1:1] == '0) ? GB'(1)
           : GB'(value_i[nsr_pkg::ValueBits-1:1]);
    end else if (cmd_i.update) begin
      g_q <= g_d;
    end
    if (cmd_i.sq_lo) begin
      pll_q <= g_lo * g_lo;
      plh_q <= g_lo * g_hi;
    end
    if (cmd_i.sq_hi) phh_q <= g_hi * g_hi;
  end

  // g^2 = lo^2 + 2 lo hi 2^25 + hi^2 2^50
  assign sq_full = SB'(pll_q) + (SB'(plh_q) << (GB - HB + 1))
                 + (SB'(phh_q) << (2 * (GB - HB)));

  always_comb begin
    sq = (sq_full[nsr_pkg::SqBits-1:64 + nsr_pkg::FracBits] != '0) ? '1
       : sq_full[63 + nsr_pkg::FracBits:nsr_pkg::FracBits];
    err = (sq > 64'(v_q)) ? sq - 64'(v_q) : 64'(v_q) - sq;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) eps_q <= (err <= 64'(epsilon_i));
  end

  assign sts_o.div_done   = ~dbusy_q & ~cmd_i.div_start;
  assign sts_o.is_zero    = (v_q == '0);
  assign sts_o.within_eps = eps_q;
  assign root_o = (v_q == '0) ? '0
                : (g_q[GB-1:nsr_pkg::RootBits] != '0) ? '1
                : g_q[nsr_pkg::RootBits-1:0];
endmodule

// File: hdl/nsr_controller.sv
// controller: sequences load, division, update, square and check per iteration
// depends on nsr_pkg
module nsr_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid,
  output logic                             in_stall,
  output logic                             out_valid,
  input  logic                             out_stall,
  input  logic [nsr_pkg::IterBits-1:0]     limit_i,
  output nsr_pkg::nsr_cmd_t                cmd_o,
  input  nsr_pkg::nsr_status_t             sts_i,
  output logic [nsr_pkg::IterBits-1:0]     iterations_o,
  output logic [1:0]                       status_o
);
  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StLoad  = 8'b00000010,
    StDiv   = 8'b00000100,
    StWait  = 8'b00001000,
    StSqLo  = 8'b00010000,
    StSqHi  = 8'b00100000,
    StCheck = 8'b01000000,
    StDone  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [nsr_pkg::CntBits-1:0] n_q, n_d, lim;
  logic [1:0] st_q, st_d;

  assign lim = (limit_i == '0) ? nsr_pkg::CntBits'(1) : limit_i;

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    st_d    = st_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: if (in_valid) begin
        cmd_o.load = 1'b1;
        state_d = StLoad;
      end
      StLoad: begin
        n_d = '0;
        if (sts_i.is_zero) begin
          st_d = nsr_pkg::StatusZero;
          state_d = StDone;
        end else begin
          cmd_o.div_start = 1'b1;
          n_d = nsr_pkg::CntBits'(1);
          state_d = StDiv;
        end
      end
      StDiv: state_d = StWait;
      StWait: if (sts_i.div_done) begin
        cmd_o.update = 1'b1;
        state_d = StSqLo;
      end
      StSqLo: begin
        cmd_o.sq_lo = 1'b1;
        cmd_o.sq_hi = 1'b1;
        state_d = StSqHi;
      end
      StSqHi: begin
        cmd_o.check = 1'b1;
        state_d = StCheck;
      end
      StCheck: begin
        if (sts_i.within_eps) begin
          st_d = nsr_pkg::StatusConverged;
          state_d = StDone;
        end else if (n_q >= lim) begin
          st_d = nsr_pkg::StatusLimit;
          state_d = StDone;
        end else begin
          cmd_o.div_start = 1'b1;
          n_d = n_q + nsr_pkg::CntBits'(1);
          state_d = StDiv;
        end
      end
      StDone: if (!out_stall) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      n_q     <= '0;
      st_q    <= nsr_pkg::StatusConverged;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      st_q    <= st_d;
    end
  end

  assign in_stall     = (state_q != StIdle);
  assign out_valid    = (state_q == StDone);
  assign iterations_o = n_q;
  assign status_o     = st_q;
endmodule

// File: hdl/nsr_checker.sv
// port-level checker of the newton square root unit, bound to the top level
// depends on nsr_pkg and newton_square_root_unit_assert.svh
`include "newton_square_root_unit_assert.svh"
module nsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [24:0] root_o,
  input logic [5:0]  iterations_o,
  input logic [1:0]  status_o
);
  logic status_ok;
  logic zero_out;

  assign status_ok = (status_o == nsr_pkg::StatusConverged) ||
                     (status_o == nsr_pkg::StatusZero) ||
                     (status_o == nsr_pkg::StatusLimit);
  assign zero_out  = out_valid && (status_o == nsr_pkg::StatusZero);

  `NSR_ASSERT(a_no_in_while_out, out_valid |-> in_stall)
  `NSR_ASSERT(a_status_code, out_valid |-> status_ok)
  `NSR_ASSERT(a_zero_iters, zero_out |-> (iterations_o == '0 && root_o == '0))
  `NSR_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(root_o)))
  `NSR_ASSERT_RST(a_reset_idle, !rst_ni |=> !out_valid)
endmodule

bind newton_square_root_unit nsr_checker u_chk (.*);
